### sv/arpc_pkg.sv
// Shared types and constants for the ARP cache responder.
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_INSERT = 2'd2;

  localparam logic [1:0] CFG_OUR_IP  = 2'd0;
  localparam logic [1:0] CFG_OUR_MAC = 2'd1;
  localparam logic [1:0] CFG_NIC     = 2'd2;

  localparam logic [10:0] MIN_ARP_LEN = 11'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OPC_REQUEST = 16'd1;

  localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
  localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] pkt_len;
    logic [15:0] hw_type;
    logic [15:0] ptype;
    logic [15:0] arp_op;
    logic [47:0] sha;
    logic [31:0] spa;
    logic [31:0] tpa;
    logic [31:0] lookup_ip;
  } req_t;

  typedef struct packed {
    logic        emit_frame;
    logic [1:0]  frame_op;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_sha;
    logic [31:0] frame_spa;
    logic [47:0] frame_tha;
    logic [31:0] frame_tpa;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic match;
    logic select;
    logic finish;
  } cmd_t;

endpackage

### sv/arpc_ctrl.sv
// Sequencer for the ARP cache responder: load, match, select, finish.
module arpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output arpc_pkg::cmd_t cmd_o
);
  import arpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   match_q;
  logic   select_q;
  logic   finish_q;
  logic   load;

  assign load = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= 1'b0;
      match_q  <= 1'b0;
      select_q <= 1'b0;
      finish_q <= 1'b0;
    end else begin
      match_q  <= 1'b0;
      select_q <= 1'b0;
      finish_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (load) begin
            state_q <= ST_MATCH;
            busy_q  <= 1'b1;
            match_q <= 1'b1;
          end
        end
        ST_MATCH: begin
          state_q  <= ST_SELECT;
          select_q <= 1'b1;
        end
        ST_SELECT: begin
          state_q  <= ST_FINISH;
          finish_q <= 1'b1;
        end
        ST_FINISH: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign cmd_o.load   = load;
  assign cmd_o.match  = match_q;
  assign cmd_o.select = select_q;
  assign cmd_o.finish = finish_q;

endmodule

### sv/arpc_dp.sv
// Datapath: config registers, binding table, parallel match and result build.
module arpc_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  arpc_pkg::cmd_t cmd_i,
  input  arpc_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [47:0]    cfg_wdata_i,
  output logic           res_valid_o,
  output arpc_pkg::res_t res_o
);
  import arpc_pkg::*;

  // Lowest set bit index; isolate then OR-encode.
  function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] vec);
    logic [TABLE_ENTRIES-1:0] onehot;
    logic [IDX_W-1:0]         idx;
    onehot = vec & (~vec + 1'b1);
    idx = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (onehot[k]) idx = idx | IDX_W'(k);
    end
    return idx;
  endfunction

  logic [31:0] our_ip_q;
  logic [47:0] our_mac_q;
  logic        nic_q;

  req_t        req_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]              ent_ip_q  [TABLE_ENTRIES];
  logic [47:0]              ent_mac_q [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] match_q;
  logic [TABLE_ENTRIES-1:0] free_q;
  logic                     store_q;
  logic                     reply_q;
  logic                     lookup_q;

  logic                     hit_q;
  logic [IDX_W-1:0]         slot_q;

  res_t                     res_q;
  logic                     res_valid_q;

  logic [31:0] key;
  logic        pkt_ok;
  res_t        res_d;

  assign key = (req_q.req_type == REQ_LOOKUP) ? req_q.lookup_ip : req_q.spa;
  assign pkt_ok = (req_q.pkt_len >= MIN_ARP_LEN) && (req_q.hw_type == HW_ETHERNET) &&
                  (req_q.ptype == PROTO_IPV4);

  always_comb begin
    res_d = '0;
    if (reply_q) begin
      res_d.emit_frame     = 1'b1;
      res_d.frame_op       = FRAME_OP_REPLY;
      res_d.frame_dest_mac = req_q.sha;
      res_d.frame_sha      = our_mac_q;
      res_d.frame_spa      = our_ip_q;
      res_d.frame_tha      = req_q.sha;
      res_d.frame_tpa      = req_q.spa;
    end else if (lookup_q) begin
      if (hit_q) begin
        res_d.lookup_hit = 1'b1;
        res_d.lookup_mac = ent_mac_q[slot_q];
      end else if (nic_q) begin
        res_d.emit_frame     = 1'b1;
        res_d.frame_op       = FRAME_OP_REQUEST;
        res_d.frame_dest_mac = MAC_BROADCAST;
        res_d.frame_sha      = our_mac_q;
        res_d.frame_spa      = our_ip_q;
        res_d.frame_tpa      = req_q.lookup_ip;
      end
    end
  end

  // Control state and config.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_ip_q    <= '0;
      our_mac_q   <= '0;
      nic_q       <= 1'b0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OUR_IP:  our_ip_q  <= cfg_wdata_i[31:0];
          CFG_OUR_MAC: our_mac_q <= cfg_wdata_i;
          CFG_NIC:     nic_q     <= cfg_wdata_i[0];
          default:     ;
        endcase
      end
      if (cmd_i.finish && store_q) valid_q[slot_q] <= 1'b1;
      res_valid_q <= cmd_i.finish;
    end
  end

  // Payload and table storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.match) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        match_q[k] <= valid_q[k] && (ent_ip_q[k] == key);
      end
      free_q   <= ~valid_q;
      store_q  <= (req_q.req_type == REQ_INSERT) ||
                  ((req_q.req_type == REQ_PACKET) && pkt_ok);
      reply_q  <= (req_q.req_type == REQ_PACKET) && pkt_ok &&
                  (req_q.arp_op == OPC_REQUEST) && (our_ip_q != '0) &&
                  (req_q.tpa == our_ip_q) && nic_q;
      lookup_q <= (req_q.req_type == REQ_LOOKUP);
    end
    if (cmd_i.select) begin
      hit_q <= |match_q;
      if (|match_q)     slot_q <= first_set(match_q);
      else if (|free_q) slot_q <= first_set(free_q);
      else              slot_q <= '0;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
      if (store_q) begin
        ent_ip_q[slot_q]  <= req_q.spa;
        ent_mac_q[slot_q] <= req_q.sha;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### sv/arp_cache_responder_top.sv
// ARP cache responder top level: controller plus datapath.
// The result is registered through the match, select and finish steps after the accepting edge.
// Items are taken one at a time: the next is accepted only after load, match, select and finish.
// The table compare runs over all entries in parallel; the slot is encoded next.
// Reset clears the valid bits, config registers and sequencer at once; no sweep.
// The receiver cannot stall: each result is strobed for exactly one cycle.
module arp_cache_responder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  arpc_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [47:0]    cfg_wdata_i,
  output logic           res_valid_o,
  output arpc_pkg::res_t res_o
);
  import arpc_pkg::*;

  cmd_t cmd;

  // Sequencer: steps one item through the datapath.
  arpc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Table, compare, slot pick, result register.
  arpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Result strobe is only seen while the sequencer is idle.
  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // Every accepted item has its result strobe raised after the match, select and finish steps.
  a_item_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 res_valid_o)
    else $error("result missing after accepted item");

  // A frame and a lookup hit never come out together.
  a_hit_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.emit_frame && res_o.lookup_hit))
    else $error("frame emitted on lookup hit");

  // No frame means a zero opcode.
  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.emit_frame) |-> (res_o.frame_op == '0))
    else $error("opcode set without frame");

endmodule

### dv/tb_arp_cache_responder_top.sv
// Self-checking testbench for the ARP cache responder top level.
module tb_arp_cache_responder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  // req_type 3 has no meaning in the block; it must come back as an all-zero result
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1830;
  localparam int unsigned PHASES       = 6;
  // Small address pool, larger than the table, so hits are common and the table overflows
  localparam int unsigned IP_POOL      = 40;
  // Wait a little longer once the queue of outstanding results is empty
  localparam int unsigned QUIET_CYCLES = 8;
  // Worst correct stretch without a transfer is a sender gap plus one item
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam logic [31:0] DIR_IP       = 32'hC0A8_0A01;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  req_t        req_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_wdata_i;
  logic        res_valid_o;
  res_t        res_o;

  // Mirror of the cache and registers; predicts each item's result and checks the DUT.
  class arp_mirror;
    bit          valid_q [TABLE_ENTRIES];
    logic [31:0] ip_q    [TABLE_ENTRIES];
    logic [47:0] mac_q   [TABLE_ENTRIES];
    logic [31:0] our_ip;
    logic [47:0] our_mac;
    logic        nic;
    res_t        answers_due[$];
    int unsigned errors, checked, replies, broadcasts, hits, evictions;
    int unsigned kinds[4];

    function new();
      our_ip  = '0;
      our_mac = '0;
      nic     = 1'b0;
      foreach (valid_q[k]) valid_q[k] = 1'b0;
    endfunction

    function void set_regs(logic [31:0] ip, logic [47:0] mac, logic nic_on);
      our_ip  = ip;
      our_mac = mac;
      nic     = nic_on;
    endfunction

    function int find_slot(logic [31:0] ip);
      int slot;
      slot = -1;
      for (int k = 0; k < int'(TABLE_ENTRIES) && slot < 0; k++)
        if (valid_q[k] && ip_q[k] == ip) slot = k;
      return slot;
    endfunction

    // Update in place, else first free entry, else entry 0 is overwritten
    function void bind_entry(logic [31:0] ip, logic [47:0] mac);
      int slot;
      slot = find_slot(ip);
      for (int k = 0; k < int'(TABLE_ENTRIES) && slot < 0; k++)
        if (!valid_q[k]) slot = k;
      if (slot < 0) begin
        slot = 0;
        evictions++;
      end
      ip_q[slot]    = ip;
      mac_q[slot]   = mac;
      valid_q[slot] = 1'b1;
    endfunction

    function void note_request(req_t r);
      res_t want;
      int   slot;
      want = '0;
      kinds[r.req_type]++;
      case (r.req_type)
        REQ_PACKET: begin
          if (r.pkt_len >= MIN_ARP_LEN && r.hw_type == HW_ETHERNET &&
              r.ptype == PROTO_IPV4) begin
            bind_entry(r.spa, r.sha);
            if (r.arp_op == OPC_REQUEST && our_ip != '0 && r.tpa == our_ip &&
                nic) begin
              want.emit_frame     = 1'b1;
              want.frame_op       = FRAME_OP_REPLY;
              want.frame_dest_mac = r.sha;
              want.frame_sha      = our_mac;
              want.frame_spa      = our_ip;
              want.frame_tha      = r.sha;
              want.frame_tpa      = r.spa;
              replies++;
            end
          end
        end
        REQ_LOOKUP: begin
          slot = find_slot(r.lookup_ip);
          if (slot >= 0) begin
            want.lookup_hit = 1'b1;
            want.lookup_mac = mac_q[slot];
            hits++;
          end else if (nic) begin
            want.emit_frame     = 1'b1;
            want.frame_op       = FRAME_OP_REQUEST;
            want.frame_dest_mac = MAC_BROADCAST;
            want.frame_sha      = our_mac;
            want.frame_spa      = our_ip;
            want.frame_tpa      = r.lookup_ip;
            broadcasts++;
          end
        end
        REQ_INSERT: bind_entry(r.spa, r.sha);
        default: ;
      endcase
      answers_due.push_back(want);
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    task flag(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        flag($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
    endtask

    task check_answer(res_t got);
      res_t want;
      if (answers_due.size() == 0) begin
        flag($sformatf("result with no item outstanding: %0h", got));
        return;
      end
      want = answers_due.pop_front();
      cmp_field("emit_frame", 64'(got.emit_frame), 64'(want.emit_frame));
      cmp_field("frame_op", 64'(got.frame_op), 64'(want.frame_op));
      cmp_field("frame_dest_mac", 64'(got.frame_dest_mac), 64'(want.frame_dest_mac));
      cmp_field("frame_sha", 64'(got.frame_sha), 64'(want.frame_sha));
      cmp_field("frame_spa", 64'(got.frame_spa), 64'(want.frame_spa));
      cmp_field("frame_tha", 64'(got.frame_tha), 64'(want.frame_tha));
      cmp_field("frame_tpa", 64'(got.frame_tpa), 64'(want.frame_tpa));
      cmp_field("lookup_hit", 64'(got.lookup_hit), 64'(want.lookup_hit));
      cmp_field("lookup_mac", 64'(got.lookup_mac), 64'(want.lookup_mac));
      checked++;
    endtask
  endclass

  arp_mirror   mirror;
  logic [31:0] ip_pool[IP_POOL];
  int unsigned n_settings;

  arp_cache_responder_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] rnd48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // Mostly addresses from the pool (cache hits, updates), sometimes a fresh one
  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 4) != 0) return ip_pool[$urandom_range(0, IP_POOL - 1)];
    return $urandom();
  endfunction

  // Ethernet/IPv4 ARP packet with the given length, other fields zero
  function automatic req_t arp_pkt(logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                                   logic [31:0] tip, logic [10:0] len);
    req_t r;
    r          = '0;
    r.req_type = REQ_PACKET;
    r.pkt_len  = len;
    r.hw_type  = HW_ETHERNET;
    r.ptype    = PROTO_IPV4;
    r.arp_op   = op;
    r.sha      = smac;
    r.spa      = sip;
    r.tpa      = tip;
    return r;
  endfunction

  function automatic req_t lookup_of(logic [31:0] ip);
    req_t r;
    r           = '0;
    r.req_type  = REQ_LOOKUP;
    r.lookup_ip = ip;
    return r;
  endfunction

  function automatic req_t insert_of(logic [31:0] ip, logic [47:0] mac);
    req_t r;
    r          = '0;
    r.req_type = REQ_INSERT;
    r.spa      = ip;
    r.sha      = mac;
    return r;
  endfunction

  // Random item: mostly well-formed packets, lookups and inserts over the address
  // pool; the rest are broken packets and unknown requests. Unused fields carry noise.
  function automatic req_t rand_item();
    req_t        r;
    int unsigned pick;
    r.req_type  = 2'($urandom());
    r.pkt_len   = 11'($urandom());
    r.hw_type   = 16'($urandom());
    r.ptype     = 16'($urandom());
    r.arp_op    = 16'($urandom());
    r.sha       = rnd48();
    r.spa       = $urandom();
    r.tpa       = $urandom();
    r.lookup_ip = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.req_type = REQ_PACKET;
      r.pkt_len  = ($urandom_range(0, 3) == 0) ? MIN_ARP_LEN
                                               : 11'($urandom_range(28, 2047));
      r.hw_type  = HW_ETHERNET;
      r.ptype    = PROTO_IPV4;
      case ($urandom_range(0, 9))
        0:       r.arp_op = 16'd2;
        1:       r.arp_op = 16'($urandom());
        default: r.arp_op = OPC_REQUEST;
      endcase
      r.spa = pick_ip();
      r.tpa = ($urandom_range(0, 9) < 6) ? mirror.our_ip : pick_ip();
    end else if (pick < 70) begin
      r.req_type  = REQ_LOOKUP;
      r.lookup_ip = pick_ip();
    end else if (pick < 85) begin
      r.req_type = REQ_INSERT;
      r.spa      = pick_ip();
    end else if (pick < 93) begin
      // broken packet: one check fails, the rest pass
      r.req_type = REQ_PACKET;
      r.pkt_len  = 11'($urandom_range(28, 2047));
      r.hw_type  = HW_ETHERNET;
      r.ptype    = PROTO_IPV4;
      r.tpa      = mirror.our_ip;
      case ($urandom_range(0, 2))
        0:       r.pkt_len = 11'($urandom_range(0, 27));
        1:       r.hw_type = 16'($urandom());
        default: r.ptype   = 16'($urandom());
      endcase
    end else begin
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every task returns right after a rising edge, so the next NBA lands
  // on the following cycle. start_i stays high across back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_item(req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    mirror.note_request(r);
  endtask

  task automatic idle_for(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every pending result is in, then let the pipeline settle
  task automatic drain();
    start_i <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Block must be idle here; writes all three registers on consecutive cycles
  task automatic program_regs(logic [31:0] ip, logic [47:0] mac, logic nic_on);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_OUR_IP;
    cfg_wdata_i <= {16'h0, ip};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_OUR_MAC;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NIC;
    cfg_wdata_i <= {47'h0, nic_on};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.set_regs(ip, mac, nic_on);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: a strobed result is taken at the edge that ends its cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) mirror.check_answer(res_o);
  end

  // Watchdog: ends the run after too many cycles with no transfer of any kind
  initial begin : watchdog
    int unsigned stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || res_valid_o || cfg_we_i) stall = 0;
      else stall++;
    end
    $display("timeout: %0d cycles with no transfer, %0d results outstanding",
             stall, mirror.pending());
    $display("arp_cache_responder_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_t        r;
    int unsigned per_phase, sent, burst;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        nic_on;

    mirror      = new();
    n_settings  = 0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_OUR_IP;
    cfg_wdata_i <= '0;

    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int k = 2; k < int'(IP_POOL); k++) ip_pool[k] = $urandom();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: register reset values (our IP zero, no NIC) ---
    send_item(lookup_of(32'h0));           // miss without NIC: nothing at all
    // request aimed at IP 0 while unconfigured: cached, never answered
    send_item(arp_pkt(OPC_REQUEST, 48'h0200_0000_0010, 32'h0A00_0001, 32'h0, MIN_ARP_LEN));
    drain();
    program_regs(DIR_IP, 48'h0200_0000_00AA, 1'b1);

    // --- directed: configured, NIC present ---
    send_item(lookup_of(32'h0A00_0001));   // hit on the binding learned above
    send_item(arp_pkt(OPC_REQUEST, '1, '1, DIR_IP, MIN_ARP_LEN));   // reply, all-ones sender
    send_item(arp_pkt(16'd2, '0, '0, DIR_IP, 11'd64));               // reply opcode: cache only
    send_item(arp_pkt(16'hFFFF, rnd48(), 32'h0A00_0002, DIR_IP, 11'd2047));
    send_item(arp_pkt(OPC_REQUEST, rnd48(), 32'h0A00_0006, DIR_IP, 11'd27));  // short
    send_item(arp_pkt(OPC_REQUEST, rnd48(), 32'h0A00_0006, DIR_IP, 11'd0));   // empty
    send_item(arp_pkt(OPC_REQUEST, rnd48(), 32'h0A00_0007, DIR_IP, 11'd2047));
    r = arp_pkt(OPC_REQUEST, rnd48(), 32'h0A00_0008, DIR_IP, MIN_ARP_LEN);
    r.hw_type = 16'h0002;                  // not Ethernet
    send_item(r);
    r.hw_type = 16'hFFFF;
    send_item(r);
    r.hw_type = HW_ETHERNET;
    r.ptype   = 16'h86DD;                  // not IPv4
    send_item(r);
    r.ptype = 16'h0000;
    send_item(r);
    send_item(insert_of(32'h0A00_0003, 48'h0));
    send_item(lookup_of(32'h0A00_0003));   // hit, MAC zero
    send_item(insert_of(32'h0A00_0003, '1));
    send_item(lookup_of(32'h0A00_0003));   // same entry, updated MAC
    send_item(lookup_of(32'h0A00_00FE));   // miss: broadcast request
    send_item(lookup_of('1));
    send_item(lookup_of('0));
    r = '1;                                // every field all ones: unknown request type
    send_item(r);
    // valid request for some other host: learned, not answered
    send_item(arp_pkt(OPC_REQUEST, rnd48(), 32'h0A00_0004, 32'h0A00_0005, MIN_ARP_LEN));

    // --- random phases, one register setting each ---
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < int'(PHASES); p++) begin
      drain();
      mac    = rnd48();
      nic_on = 1'b1;
      case (p)
        0:       ip = $urandom();
        1:       begin ip = '0; mac = '1; end
        2:       begin ip = '1; mac = '0; nic_on = 1'b0; end
        3:       ip = ip_pool[$urandom_range(0, IP_POOL-1)];
        4:       begin ip = $urandom(); nic_on = 1'b0; end
        default: ip = '1;
      endcase
      program_regs(ip, mac, nic_on);
      sent = 0;
      while (sent < per_phase) begin
        // burst of back-to-back items, then usually a short gap, so that
        // starts land on different phases of the item sequence
        burst = $urandom_range(1, 40);
        for (int b = 0; b < int'(burst) && sent < per_phase; b++) begin
          send_item(rand_item());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      end
    end

    drain();
    $display("Covered %0d packets, %0d lookups, %0d inserts, %0d unknown requests;",
             mirror.kinds[REQ_PACKET], mirror.kinds[REQ_LOOKUP], mirror.kinds[REQ_INSERT],
             mirror.kinds[REQ_UNKNOWN]);
    $display("%0d checked: %0d replies, %0d broadcasts, %0d hits, %0d evictions, %0d configs.",
             mirror.checked, mirror.replies, mirror.broadcasts, mirror.hits,
             mirror.evictions, n_settings);
    if (mirror.errors == 0) begin
      $display("arp_cache_responder_top regression: pass");
    end else begin
      $display("%0d mismatches", mirror.errors);
      $display("arp_cache_responder_top regression: fail");
    end
    $finish;
  end

endmodule
